// File: rtl/trt3d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trt3d_pkg
// Shared types and constants of the 3d turtle interpreter: fixed-point
// formats, pose layout, command symbols, status codes and transaction payloads.
// ----------------------------------------------------------------------------
package trt3d_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int STACK_CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int STACK_IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_COS_ANGLE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIN_ANGLE = 1'b1;

  typedef logic signed [15:0] q14_t;
  typedef logic signed [31:0] q16_t;
  typedef q14_t [2:0] vec14_t;
  typedef q16_t [2:0] vec16_t;

  localparam q14_t Q14_ONE  = 16'sd16384;
  localparam q14_t Q14_MAX  = 16'sh7fff;
  localparam q14_t Q14_MIN  = 16'sh8000;
  localparam q16_t Q16_MAX  = 32'sh7fffffff;
  localparam q16_t Q16_MIN  = 32'sh80000000;

  typedef struct packed {
    vec16_t pos;
    vec14_t h;
    vec14_t l;
    vec14_t u;
  } pose_t;

  // command characters
  localparam logic [7:0] SYM_YAW_POS   = 8'h2b; // '+'
  localparam logic [7:0] SYM_YAW_NEG   = 8'h2d; // '-'
  localparam logic [7:0] SYM_PITCH_POS = 8'h5e; // '^'
  localparam logic [7:0] SYM_PITCH_NEG = 8'h26; // '&'
  localparam logic [7:0] SYM_ROLL_POS  = 8'h5c; // backslash
  localparam logic [7:0] SYM_ROLL_NEG  = 8'h2f; // '/'
  localparam logic [7:0] SYM_REVERSE   = 8'h7c; // '|'
  localparam logic [7:0] SYM_PUSH      = 8'h28; // '('
  localparam logic [7:0] SYM_POP       = 8'h29; // ')'

  localparam logic [1:0] ST_SEGMENT   = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [7:0] symbol;
    logic       in_alphabet;
    logic       draws;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    q16_t       start_x;
    q16_t       start_y;
    q16_t       start_z;
    q16_t       end_x;
    q16_t       end_y;
    q16_t       end_z;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stack_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } stack_status_t;

endpackage

// File: rtl/turtle_3d_interpreter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turtle_3d_interpreter_core
// Interprets one drawing-string symbol per transaction: turns, reversal, pose
// push/pop (with overflow and underflow status) and forward moves that emit line segments.
// ----------------------------------------------------------------------------
// pipeline: two register stages, the input register and the result register;
//   a result is formed from the input register and registered in the result register
// throughput: one symbol per cycle while the output does not stall; the pose
//   update (rotation multiplies, saturating adds, stack top select) is
//   combinational between the pose registers
// reset (rst, synchronous): pose to origin facing +x, stack empty,
//   cos_angle = 1.0, sin_angle = 0, both pipeline stages empty
module turtle_3d_interpreter_core import trt3d_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_item
);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ROTATE,
    OP_REVERSE,
    OP_PUSH,
    OP_POP,
    OP_MOVE
  } op_t;

  typedef enum logic [1:0] {
    AXIS_YAW,
    AXIS_PITCH,
    AXIS_ROLL
  } axis_t;

  function automatic pose_t pose_home();
    pose_t p;
    p      = '0;
    p.h[0] = Q14_ONE;
    p.l[1] = Q14_ONE;
    p.u[2] = Q14_ONE;
    return p;
  endfunction

  function automatic q14_t neg_sat(input q14_t v);
    return (v == Q14_MIN) ? Q14_MAX : -v;
  endfunction

  function automatic q16_t move_sat(input q16_t pos, input q14_t h);
    logic signed [32:0] sum;
    sum = 33'(pos) + 33'($signed({h, 2'b00}));
    if (sum[32] != sum[31]) begin
      return sum[32] ? Q16_MIN : Q16_MAX;
    end
    return sum[31:0];
  endfunction

  q14_t          cos_angle;
  q14_t          sin_angle;
  pose_t         pose;
  pose_t         pose_next;
  logic          q_valid;
  in_item_t      q_item;
  logic          advance;
  logic          proc;
  op_t           op;
  axis_t         axis;
  logic          negate;
  vec14_t        rot_p;
  vec14_t        rot_r;
  vec14_t        rot_p_new;
  vec14_t        rot_r_new;
  stack_cmd_t    stack_cmd;
  stack_status_t stack_status;
  pose_t         stack_top;
  logic          has_result;
  out_item_t     result;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_angle <= Q14_ONE;
      sin_angle <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_COS_ANGLE: cos_angle <= cfg_data;
        CFG_SIN_ANGLE: sin_angle <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register; the result register frees it whenever it can take data
  assign advance  = !out_valid || !out_stall;
  assign proc     = q_valid && advance;
  assign in_stall = q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      q_item <= in_item;
    end
  end

  // symbol decode; command symbols win over the alphabet flag
  always_comb begin
    op     = OP_NONE;
    axis   = AXIS_YAW;
    negate = 1'b0;
    unique case (q_item.symbol)
      SYM_YAW_POS:   op = OP_ROTATE;
      SYM_YAW_NEG: begin
        op     = OP_ROTATE;
        negate = 1'b1;
      end
      SYM_PITCH_POS: begin
        op   = OP_ROTATE;
        axis = AXIS_PITCH;
      end
      SYM_PITCH_NEG: begin
        op     = OP_ROTATE;
        axis   = AXIS_PITCH;
        negate = 1'b1;
      end
      SYM_ROLL_POS: begin
        op   = OP_ROTATE;
        axis = AXIS_ROLL;
      end
      SYM_ROLL_NEG: begin
        op     = OP_ROTATE;
        axis   = AXIS_ROLL;
        negate = 1'b1;
      end
      SYM_REVERSE:   op = OP_REVERSE;
      SYM_PUSH:      op = OP_PUSH;
      SYM_POP:       op = OP_POP;
      default:       op = q_item.in_alphabet ? OP_MOVE : OP_NONE;
    endcase
  end

  // yaw turns the (heading, left) pair, pitch the (heading, up) pair, roll the (up, left) pair
  always_comb begin
    unique case (axis)
      AXIS_YAW: begin
        rot_p = pose.h;
        rot_r = pose.l;
      end
      AXIS_PITCH: begin
        rot_p = pose.h;
        rot_r = pose.u;
      end
      AXIS_ROLL: begin
        rot_p = pose.u;
        rot_r = pose.l;
      end
      default: begin
        rot_p = pose.h;
        rot_r = pose.l;
      end
    endcase
  end

  trt3d_rotator u_rotator (
    .p_in      (rot_p),
    .r_in      (rot_r),
    .cos_angle (cos_angle),
    .sin_angle (sin_angle),
    .negate    (negate),
    .p_out     (rot_p_new),
    .r_out     (rot_r_new)
  );

  assign stack_cmd.push  = proc && (op == OP_PUSH) && !stack_status.full;
  assign stack_cmd.pop   = proc && (op == OP_POP) && !stack_status.empty;
  assign stack_cmd.clear = proc && q_item.end_of_string;

  trt3d_pose_stack u_pose_stack (
    .clk       (clk),
    .rst       (rst),
    .cmd       (stack_cmd),
    .push_pose (pose),
    .top_pose  (stack_top),
    .status    (stack_status)
  );

  // pose update and result formation
  always_comb begin
    pose_next  = pose;
    has_result = 1'b0;
    result     = '0;
    unique case (op)
      OP_ROTATE: begin
        unique case (axis)
          AXIS_YAW: begin
            pose_next.h = rot_p_new;
            pose_next.l = rot_r_new;
          end
          AXIS_PITCH: begin
            pose_next.h = rot_p_new;
            pose_next.u = rot_r_new;
          end
          AXIS_ROLL: begin
            pose_next.u = rot_p_new;
            pose_next.l = rot_r_new;
          end
          default: ;
        endcase
      end
      OP_REVERSE: begin
        for (int i = 0; i < 3; i++) begin
          pose_next.h[i] = neg_sat(pose.h[i]);
          pose_next.l[i] = neg_sat(pose.l[i]);
        end
      end
      OP_PUSH: begin
        if (stack_status.full) begin
          has_result    = 1'b1;
          result.status = ST_OVERFLOW;
        end
      end
      OP_POP: begin
        if (stack_status.empty) begin
          has_result    = 1'b1;
          result.status = ST_UNDERFLOW;
        end else begin
          pose_next = stack_top;
        end
      end
      OP_MOVE: begin
        for (int i = 0; i < 3; i++) begin
          pose_next.pos[i] = move_sat(pose.pos[i], pose.h[i]);
        end
        if (q_item.draws) begin
          has_result     = 1'b1;
          result.status  = ST_SEGMENT;
          result.start_x = pose.pos[0];
          result.start_y = pose.pos[1];
          result.start_z = pose.pos[2];
          result.end_x   = pose_next.pos[0];
          result.end_y   = pose_next.pos[1];
          result.end_z   = pose_next.pos[2];
        end
      end
      OP_NONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pose <= pose_home();
    end else if (proc) begin
      pose <= q_item.end_of_string ? pose_home() : pose_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= proc && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && has_result) begin
      out_item <= result;
    end
  end

endmodule

// File: rtl/trt3d_rotator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trt3d_rotator
// Rotates a pair of orientation vectors by the configured angle:
// p' = p*c + r*s, r' = r*c - p*s, rounded to Q2.14 and saturated.
// ----------------------------------------------------------------------------
module trt3d_rotator import trt3d_pkg::*; (
  input  vec14_t p_in,
  input  vec14_t r_in,
  input  q14_t   cos_angle,
  input  q14_t   sin_angle,
  input  logic   negate,
  output vec14_t p_out,
  output vec14_t r_out
);

  localparam logic signed [34:0] ROUND_HALF = 35'sd8192;
  localparam logic signed [20:0] SAT_HI = 21'sd32767;
  localparam logic signed [20:0] SAT_LO = -21'sd32768;

  // a*b + x*y in Q4.28, round half up to Q2.14, saturate
  function automatic q14_t mac_round(input logic signed [15:0] a,
                                     input logic signed [16:0] b,
                                     input logic signed [15:0] x,
                                     input logic signed [16:0] y);
    logic signed [32:0] prod_ab;
    logic signed [32:0] prod_xy;
    logic signed [34:0] acc;
    logic signed [20:0] quo;
    prod_ab = a * b;
    prod_xy = x * y;
    acc = 35'(prod_ab) + 35'(prod_xy) + ROUND_HALF;
    quo = 21'(acc >>> 14);
    if (quo > SAT_HI) begin
      return Q14_MAX;
    end else if (quo < SAT_LO) begin
      return Q14_MIN;
    end
    return quo[15:0];
  endfunction

  logic signed [16:0] c_ext;
  logic signed [16:0] s_eff;
  logic signed [16:0] s_neg;

  always_comb begin
    c_ext = 17'(cos_angle);
    s_eff = negate ? -17'(sin_angle) : 17'(sin_angle);
    s_neg = -s_eff;
    for (int i = 0; i < 3; i++) begin
      p_out[i] = mac_round(p_in[i], c_ext, r_in[i], s_eff);
      r_out[i] = mac_round(p_in[i], s_neg, r_in[i], c_ext);
    end
  end

endmodule

// File: rtl/trt3d_pose_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trt3d_pose_stack
// Bounded push/pop store of saved poses with a fill count; the top entry is
// presented for a pop, full and empty flags guard overflow and underflow.
// ----------------------------------------------------------------------------
module trt3d_pose_stack import trt3d_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  stack_cmd_t    cmd,
  input  pose_t         push_pose,
  output pose_t         top_pose,
  output stack_status_t status
);

  pose_t                  entries [STACK_DEPTH];
  logic [STACK_CNT_W-1:0] count;
  logic [STACK_CNT_W-1:0] count_next;
  logic [STACK_CNT_W-1:0] top_ptr;

  assign top_ptr      = count - 1'b1;
  assign top_pose     = entries[top_ptr[STACK_IDX_W-1:0]];
  assign status.full  = (count == STACK_CNT_W'(STACK_DEPTH));
  assign status.empty = (count == '0);

  always_comb begin
    count_next = count;
    if (cmd.clear) begin
      count_next = '0;
    end else if (cmd.push) begin
      count_next = count + 1'b1;
    end else if (cmd.pop) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // entries hold no reset value; only entries below the count are used
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      entries[count[STACK_IDX_W-1:0]] <= push_pose;
    end
  end

endmodule
